// ===== design/glsp_pkg.sv =====
// Shared types and constants for the grid layered shortest path block.
package glsp_pkg;
    localparam logic [39:0] MASK40 = 40'hFF_FFFF_FFFF;
    // reachable distances stay far below 2^40, so all ones marks unreached
    localparam logic [39:0] DIST_INF = MASK40;
    localparam int COST_W = 20;
    localparam int DIST_W = 40;
    localparam int SIDE_W = 8;

    localparam logic [0:0] REG_SIDE = 1'b0;
    localparam logic [0:0] REG_STEP = 1'b1;

    typedef struct packed {
        logic start;
        logic busy;
    } ctl_t;
endpackage

// ===== design/glsp_cost_mem.sv =====
// Cell cost memory: one write port for loading, one registered read port.
module glsp_cost_mem #(
    parameter int DEPTH = 16384,
    parameter int AW = 14
) (
    input  logic                            aclk,
    input  logic                            we,
    input  logic [AW-1:0]                   waddr,
    input  logic [glsp_pkg::COST_W-1:0]     wdata,
    input  logic [AW-1:0]                   raddr,
    output logic [glsp_pkg::COST_W-1:0]     rdata
);
    logic [glsp_pkg::COST_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/glsp_search.sv =====
// Scan-based search sequencer: clear pass, minimum scan, neighbour relax.
module glsp_search #(
    parameter int MAX_SIDE = 128,
    parameter int CW = 14,
    parameter int SW = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  glsp_pkg::ctl_t                  ctl,
    input  logic [glsp_pkg::SIDE_W-1:0]     side,
    input  logic [19:0]                     step_time,
    output logic [CW-1:0]                   cost_addr,
    input  logic [glsp_pkg::COST_W-1:0]     cost_data,
    output logic                            done,
    output logic [glsp_pkg::DIST_W-1:0]     result
);
    localparam int NCELLS = MAX_SIDE * MAX_SIDE;
    localparam int NSTATES = 3 * NCELLS;

    localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_SCAN = 4'd2,
        S_SCANW = 4'd3, S_PICK = 4'd4, S_NB = 4'd5, S_CRD = 4'd6,
        S_DRD = 4'd7, S_UPD = 4'd8, S_FIN = 4'd9, S_FINW = 4'd10, S_DONE = 4'd11;

    logic [3:0] state_reg;
    logic [SW:0] idx_reg;
    logic [glsp_pkg::DIST_W-1:0] dist_mem [NSTATES];
    logic vis_mem [NSTATES];
    logic [glsp_pkg::DIST_W-1:0] rd_dist;
    logic rd_vis;
    logic [SW-1:0] raddr, waddr;
    logic we_d, we_v;
    logic [glsp_pkg::DIST_W-1:0] wd_dist;

    logic [glsp_pkg::DIST_W-1:0] best_reg, curd_reg, nd_reg;
    logic [SW-1:0] best_st_reg, nst_reg;
    logic best_ok_reg;
    logic [1:0] ph_reg, k_reg;
    logic [7:0] row_reg, col_reg, nr, nc;
    logic [SW-1:0] sidx_reg;
    logic [1:0] sph_reg;
    logic [7:0] srow_reg, scol_reg;
    logic [1:0] fin_reg;
    logic [glsp_pkg::DIST_W-1:0] res_reg;
    logic nb_ok;
    logic [7:0] nr_keep_row, nr_keep_col;

    always_ff @(posedge aclk) begin
        if (we_d) dist_mem[waddr] <= wd_dist;
        if (we_v) vis_mem[waddr] <= (state_reg != S_CLR);
        rd_dist <= dist_mem[raddr];
        rd_vis <= vis_mem[raddr];
    end

    // neighbour of current cell for direction k
    always_comb begin
        nr = row_reg;
        nc = col_reg;
        nb_ok = 1'b1;
        case (k_reg)
            2'd0: begin nb_ok = (row_reg != 8'd0); nr = row_reg - 8'd1; end
            2'd1: begin nb_ok = ({1'b0, row_reg} + 9'd1 < {1'b0, side}); nr = row_reg + 8'd1; end
            2'd2: begin nb_ok = (col_reg != 8'd0); nc = col_reg - 8'd1; end
            default: begin nb_ok = ({1'b0, col_reg} + 9'd1 < {1'b0, side}); nc = col_reg + 8'd1; end
        endcase
    end

    logic [1:0] nph;
    logic [CW-1:0] ncell;
    assign nph = (ph_reg == 2'd2) ? 2'd0 : ph_reg + 2'd1;
    assign ncell = CW'(16'(nr) * 16'(side) + 16'(nc));
    assign cost_addr = ncell;

    always_comb begin
        raddr = idx_reg[SW-1:0];
        waddr = idx_reg[SW-1:0];
        we_d = 1'b0;
        we_v = 1'b0;
        wd_dist = glsp_pkg::DIST_INF;
        case (state_reg)
            S_CLR: begin
                we_d = 1'b1; we_v = 1'b1;
                wd_dist = (idx_reg == '0) ? '0 : glsp_pkg::DIST_INF;
            end
            S_SCAN: raddr = sidx_reg;
            S_PICK: begin waddr = best_st_reg; we_v = best_ok_reg; end
            S_CRD, S_DRD: raddr = nst_reg;
            S_UPD: begin
                waddr = nst_reg;
                we_d = !rd_vis && (nd_reg < rd_dist);
                wd_dist = nd_reg;
            end
            S_FIN: raddr = SW'(32'(fin_reg) * NCELLS + 32'(side) * 32'(side) - 1);
            default: ;
        endcase
    end

    // scan entry address walks phase-major, only over cells in use
    logic [8:0] side9;
    assign side9 = {1'b0, side};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE: if (ctl.start) begin
                    idx_reg <= '0;
                    state_reg <= S_CLR;
                end
                S_CLR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (SW+1)'(NSTATES - 1)) state_reg <= S_SCAN;
                    sidx_reg <= '0; sph_reg <= '0; srow_reg <= '0; scol_reg <= '0;
                    best_ok_reg <= 1'b0; best_reg <= glsp_pkg::DIST_INF;
                end
                S_SCAN: begin
                    // issue read of current scan entry; the position advances in S_SCANW
                    idx_reg <= {1'b0, sidx_reg};
                    ph_reg <= sph_reg; row_reg <= srow_reg; col_reg <= scol_reg;
                    state_reg <= S_SCANW;
                end
                S_SCANW: begin
                    if (!rd_vis && rd_dist < best_reg) begin
                        best_reg <= rd_dist;
                        best_st_reg <= idx_reg[SW-1:0];
                        best_ok_reg <= 1'b1;
                        fin_reg <= ph_reg;
                        nr_keep_row <= row_reg; nr_keep_col <= col_reg;
                    end
                    if ({1'b0, scol_reg} + 9'd1 < side9) begin
                        scol_reg <= scol_reg + 8'd1;
                        sidx_reg <= sidx_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end else if ({1'b0, srow_reg} + 9'd1 < side9) begin
                        scol_reg <= '0; srow_reg <= srow_reg + 8'd1;
                        sidx_reg <= SW'(32'(sph_reg) * NCELLS
                            + (32'(srow_reg) + 1) * 32'(side));
                        state_reg <= S_SCAN;
                    end else if (sph_reg != 2'd2) begin
                        scol_reg <= '0; srow_reg <= '0; sph_reg <= sph_reg + 2'd1;
                        sidx_reg <= SW'((32'(sph_reg) + 1) * NCELLS);
                        state_reg <= S_SCAN;
                    end else begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (best_ok_reg) begin
                        curd_reg <= best_reg;
                        ph_reg <= fin_reg;
                        row_reg <= nr_keep_row; col_reg <= nr_keep_col;
                        k_reg <= 2'd0;
                        state_reg <= S_NB;
                    end else begin
                        fin_reg <= 2'd0;
                        res_reg <= glsp_pkg::DIST_INF;
                        state_reg <= S_FIN;
                    end
                end
                S_NB: begin
                    if (nb_ok) begin
                        nst_reg <= SW'(32'(nph) * NCELLS + 32'(ncell));
                        state_reg <= S_CRD;
                    end else if (k_reg == 2'd3) begin
                        sidx_reg <= '0; sph_reg <= '0; srow_reg <= '0; scol_reg <= '0;
                        best_ok_reg <= 1'b0; best_reg <= glsp_pkg::DIST_INF;
                        state_reg <= S_SCAN;
                    end else begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                S_CRD: state_reg <= S_DRD;
                S_DRD: begin
                    nd_reg <= curd_reg + 40'(step_time)
                        + ((ph_reg == 2'd2) ? 40'(cost_data) : 40'd0);
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    if (k_reg == 2'd3) begin
                        sidx_reg <= '0; sph_reg <= '0; srow_reg <= '0; scol_reg <= '0;
                        best_ok_reg <= 1'b0; best_reg <= glsp_pkg::DIST_INF;
                        state_reg <= S_SCAN;
                    end else begin
                        k_reg <= k_reg + 2'd1;
                        state_reg <= S_NB;
                    end
                end
                S_FIN: state_reg <= S_FINW;
                S_FINW: begin
                    if (rd_dist < res_reg) res_reg <= rd_dist;
                    if (fin_reg == 2'd2) state_reg <= S_DONE;
                    else begin
                        fin_reg <= fin_reg + 2'd1;
                        state_reg <= S_FIN;
                    end
                end
                S_DONE: begin
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result = res_reg;
endmodule

// ===== design/grid_layered_shortest_path.sv =====
// Top level: cost loading, configuration and result register.
// Loading: one word per cycle while s_ready is high. A word with last_cell set starts a search.
// Search: a clear pass over all 3*MAX_SIDE^2 states, then per visited state a scan over
// the distance memory and a relax of up to four neighbours.
// Not ready during the search; the result waits in an output register.
// Reset (synchronous, active low): grid_side 1, step_time 0, load position 0.
module grid_layered_shortest_path #(
    parameter int MAX_SIDE = 128
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [19:0]  cfg_data,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [19:0]  s_cell_cost,
    input  logic         s_last_cell,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [39:0]  m_shortest_time
);
    localparam int NCELLS = MAX_SIDE * MAX_SIDE;
    localparam int CW = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int SW = $clog2(3 * NCELLS);

    logic [7:0] side_reg, side_eff;
    logic [19:0] step_reg;
    logic [CW-1:0] pos_reg;
    logic busy_reg;
    logic acc;
    logic done;
    logic [39:0] res;
    logic [CW-1:0] raddr;
    logic [19:0] rdata;
    glsp_pkg::ctl_t ctl;

    assign s_ready = !busy_reg && !m_valid;
    assign acc = s_valid && s_ready;
    assign ctl.start = acc && s_last_cell;
    assign ctl.busy = busy_reg;
    assign side_eff = (side_reg == 8'd0) ? 8'd1 :
        ((32'(side_reg) > MAX_SIDE) ? 8'(MAX_SIDE) : side_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= 8'd1;
            step_reg <= '0;
            pos_reg <= '0;
            busy_reg <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == glsp_pkg::REG_SIDE) side_reg <= cfg_data[7:0];
                else if (cfg_index == glsp_pkg::REG_STEP) step_reg <= cfg_data;
            end
            if (acc) begin
                // wrap at end of cost store, restart after last cell
                if (s_last_cell || pos_reg == CW'(NCELLS - 1)) pos_reg <= '0;
                else pos_reg <= pos_reg + 1'b1;
            end
            if (ctl.start) busy_reg <= 1'b1;
            if (done) begin
                busy_reg <= 1'b0;
                m_valid <= 1'b1;
                m_shortest_time <= (res > glsp_pkg::MASK40) ? glsp_pkg::MASK40 : res;
            end else if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    glsp_cost_mem #(.DEPTH(NCELLS), .AW(CW)) u_cost (
        .aclk(aclk), .we(acc), .waddr(pos_reg), .wdata(s_cell_cost),
        .raddr(raddr), .rdata(rdata)
    );

    glsp_search #(.MAX_SIDE(MAX_SIDE), .CW(CW), .SW(SW)) u_search (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .side(side_eff),
        .step_time(step_reg), .cost_addr(raddr), .cost_data(rdata),
        .done(done), .result(res)
    );
endmodule

// ===== tb/tb_top.sv =====
// Testbench for the grid layered shortest path block: grid loads with scoreboard checks.
`timescale 1ns / 1ps

module tb_top;
    localparam int COST_DEPTH = 16384;
    localparam logic [19:0] COST_MAX = 20'hFFFFF;

    class path_scoreboard;
        bit [19:0] costs [COST_DEPTH];
        int unsigned load_pos;
        int unsigned written;
        bit [7:0] side;
        bit [19:0] step;
        logic [39:0] expected_times [$];
        int errors;

        function new();
            load_pos = 0;
            written = 0;
            side = 1;
            step = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [0:0] idx, bit [19:0] value);
            if (idx == glsp_pkg::REG_SIDE) side = value[7:0];
            else step = value;
        endfunction

        function int unsigned eff_side();
            if (side == 0) return 1;
            if (side > 128) return 128;
            return side;
        endfunction

        // Dijkstra with selection by scan over (phase, cell) states.
        function logic [39:0] shortest();
            longint unsigned dist_arr [];
            bit seen [];
            int unsigned s, n, best_i, cur, ph, cell_i, r, c, k, nr, nc, nst;
            longint unsigned best, nd;
            bit found;
            s = eff_side();
            n = s * s;
            dist_arr = new[3 * n];
            seen = new[3 * n];
            foreach (dist_arr[i]) begin
                dist_arr[i] = glsp_pkg::DIST_INF;
                seen[i] = 0;
            end
            dist_arr[0] = 0;
            forever begin
                found = 0;
                best = glsp_pkg::DIST_INF;
                best_i = 0;
                foreach (dist_arr[i]) begin
                    if (!seen[i] && dist_arr[i] < best) begin
                        best = dist_arr[i];
                        best_i = i;
                        found = 1;
                    end
                end
                if (!found) break;
                cur = best_i;
                seen[cur] = 1;
                ph = cur / n;
                cell_i = cur % n;
                r = cell_i / s;
                c = cell_i % s;
                for (k = 0; k < 4; k++) begin
                    nr = r;
                    nc = c;
                    if (k == 0) begin
                        if (r == 0) continue;
                        nr = r - 1;
                    end else if (k == 1) begin
                        if (r + 1 >= s) continue;
                        nr = r + 1;
                    end else if (k == 2) begin
                        if (c == 0) continue;
                        nc = c - 1;
                    end else begin
                        if (c + 1 >= s) continue;
                        nc = c + 1;
                    end
                    nst = ((ph + 1) % 3) * n + nr * s + nc;
                    nd = dist_arr[cur] + step;
                    if (ph == 2) nd += costs[nr * s + nc];
                    if (!seen[nst] && nd < dist_arr[nst]) dist_arr[nst] = nd;
                end
            end
            best = glsp_pkg::DIST_INF;
            for (k = 0; k < 3; k++) begin
                if (dist_arr[k * n + n - 1] < best) best = dist_arr[k * n + n - 1];
            end
            if (best > glsp_pkg::MASK40) best = glsp_pkg::MASK40;
            return best[39:0];
        endfunction

        function void note_word(bit [19:0] cost, bit last);
            costs[load_pos] = cost;
            if (load_pos + 1 > written) written = load_pos + 1;
            load_pos = (load_pos + 1 >= COST_DEPTH) ? 0 : load_pos + 1;
            if (last) begin
                load_pos = 0;
                expected_times.insert(expected_times.size(), shortest());
            end
        endfunction

        function void check_result(logic [39:0] actual);
            logic [39:0] exp_time;
            if (expected_times.size() == 0) begin
                $error("shortest_time expected none actual %0d", actual);
                errors++;
            end else begin
                exp_time = expected_times.pop_front();
                if (actual !== exp_time) begin
                    $error("shortest_time expected %0d actual %0d", exp_time, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [0:0] cfg_index = 0;
    logic [19:0] cfg_data = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [19:0] s_cell_cost = 0;
    logic s_last_cell = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [39:0] m_shortest_time;

    path_scoreboard sb = new();
    int sent_words = 0;
    bit quiet = 0;

    grid_layered_shortest_path uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cell_cost(s_cell_cost), .s_last_cell(s_last_cell),
        .m_valid(m_valid), .m_ready(m_ready), .m_shortest_time(m_shortest_time)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    initial begin
        #1_000_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off to back up the input.
    initial begin
        int stall_left;
        int hold_left;
        bit held;
        stall_left = 0;
        hold_left = 0;
        held = 0;
        forever begin
            @(negedge aclk);
            if (m_valid && m_ready) sb.check_result(m_shortest_time);
            if (m_valid && !held) begin
                held = 1;
                hold_left = 120000;
            end
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    // Called right after a rising edge; leaves the word accepted at the last edge.
    task automatic send_word(bit [19:0] cost, bit last);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_cell_cost <= cost;
        s_last_cell <= last;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
            @(posedge aclk);
        end
        @(posedge aclk);
        sb.note_word(cost, last);
        sent_words++;
    endtask

    task automatic drain();
        while (sb.expected_times.size() != 0) @(posedge aclk);
        s_valid <= 0;
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, bit [19:0] value);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 0;
        sb.set_reg(idx, value);
        @(posedge aclk);
    endtask

    function automatic bit [19:0] rand_cost();
        case ($urandom_range(0, 3))
            0: return 20'($urandom_range(0, 15));
            1: return COST_MAX;
            default: return 20'($urandom() & 32'(COST_MAX));
        endcase
    endfunction

    // One grid load: count may be short of side^2 once the cells are written.
    task automatic send_grid(int unsigned count, bit fixed_cost, bit [19:0] cost);
        int unsigned i;
        for (i = 0; i < count; i++) begin
            send_word(fixed_cost ? cost : rand_cost(), i == count - 1);
        end
    endtask

    initial begin
        int unsigned s, n, g;
        bit [19:0] step_val;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Side above the maximum and full step, then a zero side.
        write_reg(glsp_pkg::REG_SIDE, 8'd255);
        write_reg(glsp_pkg::REG_STEP, COST_MAX);
        write_reg(glsp_pkg::REG_SIDE, 8'd0);
        send_grid(1, 1, COST_MAX);
        drain();
        write_reg(glsp_pkg::REG_SIDE, 8'd1);
        send_grid(3, 1, 20'd5);
        drain();
        write_reg(glsp_pkg::REG_SIDE, 8'd2);
        send_grid(4, 1, COST_MAX);
        drain();
        write_reg(glsp_pkg::REG_STEP, 20'd0);
        send_grid(4, 1, 20'd0);
        send_grid(4, 0, 20'd0);
        drain();
        write_reg(glsp_pkg::REG_SIDE, 8'd3);
        write_reg(glsp_pkg::REG_STEP, 20'd1);
        send_grid(9, 0, 20'd0);
        send_grid(5, 1, 20'hAAAAA);
        drain();

        while (sent_words < 950) begin
            if (sent_words >= 850) quiet = 1;
            s = ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(0, 5);
            case ($urandom_range(0, 3))
                0: step_val = 0;
                1: step_val = COST_MAX;
                2: step_val = 20'($urandom_range(1, 100));
                default: step_val = 20'($urandom() & 32'(COST_MAX));
            endcase
            write_reg(glsp_pkg::REG_SIDE, s[7:0]);
            write_reg(glsp_pkg::REG_STEP, step_val);
            if (s == 0) s = 1;
            for (g = 0; g < 3; g++) begin
                n = s * s + $urandom_range(0, 30);
                if ($urandom_range(0, 4) == 0) n = $urandom_range(1, s * s);
                if (n < s * s && sb.written < s * s) n = s * s;
                send_grid(n, 0, 20'd0);
            end
            drain();
        end

        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_times.size() == 0) begin
            $display("status: pass");
        end else begin
            if (sb.expected_times.size() != 0)
                $error("shortest_time expected %0d results left", sb.expected_times.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule
